// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VIU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VIU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/viu_pkg.sv =====
// ----------------------------------------------------------------------------
// viu_pkg
// Shared types, codes and datapath functions of the vector immediate unit.
// ----------------------------------------------------------------------------
package viu_pkg;

	localparam int VIU_NUM_VREGS      = 32;
	localparam int VIU_WORDS_PER_VREG = 4;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_LDI = 2'd2,
		FUNC_LDW = 2'd3
	} viu_func_t;

	localparam logic [1:0] ES_BYTE = 2'd0;
	localparam logic [1:0] ES_HALF = 2'd1;
	localparam logic [1:0] ES_WORD = 2'd2;
	localparam logic [1:0] ES_DBL  = 2'd3;

	// pattern modes, bit 12 clear
	localparam logic [1:0] PMS_BYTE = 2'd0;
	localparam logic [1:0] PMS_HALF = 2'd1;
	localparam logic [1:0] PMS_WORD = 2'd2;

	// pattern modes, bit 12 set
	localparam logic [3:0] PM_SH0    = 4'd0;
	localparam logic [3:0] PM_SH8    = 4'd1;
	localparam logic [3:0] PM_SH16   = 4'd2;
	localparam logic [3:0] PM_SH24   = 4'd3;
	localparam logic [3:0] PM_H0     = 4'd4;
	localparam logic [3:0] PM_H8     = 4'd5;
	localparam logic [3:0] PM_ONES8  = 4'd6;
	localparam logic [3:0] PM_ONES16 = 4'd7;
	localparam logic [3:0] PM_BYTES  = 4'd8;
	localparam logic [3:0] PM_BMASK  = 4'd9;
	localparam logic [3:0] PM_FSGL2  = 4'd10;
	localparam logic [3:0] PM_FSGL1  = 4'd11;
	localparam logic [3:0] PM_FDBL   = 4'd12;

	// one queued operation, already classified by the front end
	typedef struct packed {
		viu_func_t   func;
		logic [1:0]  es;
		logic [4:0]  dst;
		logic [4:0]  src;
		logic        src_ok;
		logic [4:0]  imm;
		logic [63:0] value;
		logic [1:0]  first_word;
		logic [1:0]  end_word;
	} viu_cmd_t;

	// lane-wise add/sub of a zero-extended 5-bit immediate, wrapping per lane
	function automatic logic [63:0] viu_lane_arith(input logic [63:0] w,
			input logic [1:0] es, input logic [4:0] imm, input logic sub);
		logic [7:0]  i8;
		logic [15:0] i16;
		logic [31:0] i32;
		logic [63:0] i64;
		logic [63:0] rb, rh, rw, rd;
		logic [63:0] res;
		int k;
		i8  = sub ? (8'd0 - {3'b0, imm}) : {3'b0, imm};
		i16 = sub ? (16'd0 - {11'b0, imm}) : {11'b0, imm};
		i32 = sub ? (32'd0 - {27'b0, imm}) : {27'b0, imm};
		i64 = sub ? (64'd0 - {59'b0, imm}) : {59'b0, imm};
		for (k = 0; k < 8; k++)
			rb[k*8 +: 8] = w[k*8 +: 8] + i8;
		for (k = 0; k < 4; k++)
			rh[k*16 +: 16] = w[k*16 +: 16] + i16;
		for (k = 0; k < 2; k++)
			rw[k*32 +: 32] = w[k*32 +: 32] + i32;
		rd = w + i64;
		case (es)
			ES_BYTE: res = rb;
			ES_HALF: res = rh;
			ES_WORD: res = rw;
			ES_DBL:  res = rd;
			default: res = rd;
		endcase
		return res;
	endfunction

	// 13-bit immediate to 64-bit pattern
	function automatic logic [63:0] viu_expand(input logic [12:0] x);
		logic [7:0]  t;
		logic [15:0] s16;
		logic [31:0] s32;
		logic [31:0] f;
		logic [63:0] bm;
		logic [63:0] res;
		int k;
		t   = x[7:0];
		s16 = {{6{x[9]}}, x[9:0]};
		s32 = {{22{x[9]}}, x[9:0]};
		f   = {x[7], ~x[6], {5{x[6]}}, x[5:0], 19'b0};
		for (k = 0; k < 8; k++)
			bm[k*8 +: 8] = {8{t[k]}};
		if (!x[12]) begin
			case (x[11:10])
				PMS_BYTE: res = {8{t}};
				PMS_HALF: res = {4{s16}};
				PMS_WORD: res = {2{s32}};
				default:  res = {{54{x[9]}}, x[9:0]};
			endcase
		end else begin
			case (x[11:8])
				PM_SH0:    res = {2{24'b0, t}};
				PM_SH8:    res = {2{16'b0, t, 8'b0}};
				PM_SH16:   res = {2{8'b0, t, 16'b0}};
				PM_SH24:   res = {2{t, 24'b0}};
				PM_H0:     res = {4{8'b0, t}};
				PM_H8:     res = {4{t, 8'b0}};
				PM_ONES8:  res = {2{16'b0, t, 8'hff}};
				PM_ONES16: res = {2{8'b0, t, 16'hffff}};
				PM_BYTES:  res = {8{t}};
				PM_BMASK:  res = bm;
				PM_FSGL2:  res = {2{f}};
				PM_FSGL1:  res = {32'b0, f};
				PM_FDBL:   res = {x[7], ~x[6], {8{x[6]}}, x[5:0], 48'b0};
				default:   res = 64'b0;
			endcase
		end
		return res;
	endfunction

endpackage

// ===== design/viu_ram.sv =====
// ----------------------------------------------------------------------------
// viu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module viu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== design/viu_front.sv =====
// ----------------------------------------------------------------------------
// viu_front
// Accepts input words, drops operations that write nothing, expands the
// load-immediate pattern and builds the queued command.
// ----------------------------------------------------------------------------
module viu_front import viu_pkg::*; #(
	parameter int NUM_VREGS      = VIU_NUM_VREGS,
	parameter int WORDS_PER_VREG = VIU_WORDS_PER_VREG
) (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  elem_size,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src_reg,
	input  logic [4:0]  small_imm,
	input  logic [12:0] pattern_imm,
	input  logic [1:0]  load_word_index,
	input  logic [63:0] load_word_data,
	input  logic        q_full,
	output logic        push,
	output viu_cmd_t    cmd
);

	localparam logic [1:0] TOP_WORD = 2'(WORDS_PER_VREG - 1);

	viu_func_t fn;
	logic      dst_ok;
	logic      idx_ok;
	logic      keep;

	assign fn     = viu_func_t'(func);
	assign dst_ok = ({1'b0, dest_reg} < 6'(NUM_VREGS));
	assign idx_ok = ({1'b0, load_word_index} < 3'(WORDS_PER_VREG));
	assign keep   = dst_ok && ((fn != FUNC_LDW) || idx_ok);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full && keep;

	always_comb begin
		cmd.func       = fn;
		cmd.es         = elem_size;
		cmd.dst        = dest_reg;
		cmd.src        = src_reg;
		cmd.src_ok     = ({1'b0, src_reg} < 6'(NUM_VREGS));
		cmd.imm        = small_imm;
		cmd.first_word = 2'd0;
		cmd.end_word   = TOP_WORD;
		case (fn)
			FUNC_LDI: cmd.value = viu_expand(pattern_imm);
			FUNC_LDW: begin
				cmd.value      = load_word_data;
				cmd.first_word = load_word_index;
				cmd.end_word   = load_word_index;
			end
			default:  cmd.value = load_word_data;
		endcase
	end

endmodule

// ===== design/viu_queue.sv =====
// ----------------------------------------------------------------------------
// viu_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module viu_queue import viu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  viu_cmd_t push_cmd,
	input  logic     pop,
	output viu_cmd_t head,
	output logic     empty,
	output logic     full
);

	viu_cmd_t   ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wptr_q] <= push_cmd;
	end

endmodule

// ===== design/viu_back.sv =====
// ----------------------------------------------------------------------------
// viu_back
// Executes queued commands one register word per cycle unless the output stalls:
// reads the source word, modifies it, writes it and loads the output register.
// ----------------------------------------------------------------------------
module viu_back import viu_pkg::*; #(
	parameter int NUM_VREGS      = VIU_NUM_VREGS,
	parameter int WORDS_PER_VREG = VIU_WORDS_PER_VREG
) (
	input  logic        clk,
	input  logic        arst_n,
	input  viu_cmd_t    head,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  written_reg,
	output logic [1:0]  word_index,
	output logic [63:0] word_value,
	output logic        last_word
);

	localparam int RW    = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;
	localparam int WB    = (WORDS_PER_VREG > 1) ? $clog2(WORDS_PER_VREG) : 1;
	localparam int AW    = RW + WB;
	localparam int DEPTH = NUM_VREGS * (1 << WB);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} viu_state_t;

	viu_state_t  state_q;
	viu_cmd_t    cmd_q;
	logic [1:0]  word_q;
	logic [DEPTH-1:0] vld_q;
	logic        rd_vld_s1;

	logic        out_valid_q;
	logic [4:0]  out_reg_q;
	logic [1:0]  out_word_q;
	logic [63:0] out_value_q;
	logic        out_last_q;

	logic        out_free;
	logic        fire;
	logic        done;
	logic        conflict;
	logic        rd_en;
	logic [1:0]  next_word;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] head_addr;
	logic [63:0] rd_data;
	logic [63:0] src_word;
	logic [63:0] result;

	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = (state_q == ST_RUN) && out_free;
	assign done      = fire && (word_q == cmd_q.end_word);
	assign next_word = word_q + 2'd1;

	assign wr_addr   = {cmd_q.dst[RW-1:0], word_q[WB-1:0]};
	assign head_addr = {head.src[RW-1:0], head.first_word[WB-1:0]};
	// next command may start in the last-word cycle unless it reads the
	// word being written right then
	assign conflict  = (head_addr == wr_addr);
	assign pop       = !q_empty && ((state_q == ST_IDLE) || (done && !conflict));
	assign rd_en     = pop || (fire && !done);
	assign rd_addr   = pop ? head_addr : {cmd_q.src[RW-1:0], next_word[WB-1:0]};

	viu_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (fire),
		.waddr (wr_addr),
		.wdata (result),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign src_word = (rd_vld_s1 && cmd_q.src_ok) ? rd_data : 64'd0;

	always_comb begin
		case (cmd_q.func)
			FUNC_ADD: result = viu_lane_arith(src_word, cmd_q.es, cmd_q.imm, 1'b0);
			FUNC_SUB: result = viu_lane_arith(src_word, cmd_q.es, cmd_q.imm, 1'b1);
			FUNC_LDI: result = cmd_q.value;
			FUNC_LDW: result = cmd_q.value;
			default:  result = cmd_q.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				state_q <= ST_RUN;
			else if (done)
				state_q <= ST_IDLE;
			if (fire)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_s1 <= vld_q[rd_addr];
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= head;
			word_q <= head.first_word;
		end else if (fire) begin
			word_q <= next_word;
		end
		if (fire) begin
			out_reg_q   <= cmd_q.dst;
			out_word_q  <= word_q;
			out_value_q <= result;
			out_last_q  <= (word_q == cmd_q.end_word);
		end
	end

	assign out_valid   = out_valid_q;
	assign written_reg = out_reg_q;
	assign word_index  = out_word_q;
	assign word_value  = out_value_q;
	assign last_word   = out_last_q;

endmodule

// ===== design/vector_immediate_unit.sv =====
// ----------------------------------------------------------------------------
// vector_immediate_unit
// Vector register file with lane-wise add/sub immediate, pattern load and
// single-word load.
// ----------------------------------------------------------------------------
// Add, subtract and load-pattern each emit WORDS_PER_VREG result words (4 by
// default), one per cycle while the output is not stalled; a load-word item
// emits one. The rate is set by the register file memory, which gives one
// read and one write per cycle. An operation whose first read hits the word
// written in the previous operation's final cycle is not started in that
// cycle but only from the idle state. The two-entry command queue lets input
// keep flowing while the output is stalled, until it is full. Registers read
// as zero until written; no clearing pass is needed after reset. Operations
// with an out-of-range destination, or a load word beyond the register, are
// accepted and dropped.
// ----------------------------------------------------------------------------
module vector_immediate_unit import viu_pkg::*; #(
	parameter int NUM_VREGS      = VIU_NUM_VREGS,
	parameter int WORDS_PER_VREG = VIU_WORDS_PER_VREG
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  elem_size,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src_reg,
	input  logic [4:0]  small_imm,
	input  logic [12:0] pattern_imm,
	input  logic [1:0]  load_word_index,
	input  logic [63:0] load_word_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  written_reg,
	output logic [1:0]  word_index,
	output logic [63:0] word_value,
	output logic        last_word
);

	viu_cmd_t push_cmd;
	viu_cmd_t head;
	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;

	viu_front #(
		.NUM_VREGS      (NUM_VREGS),
		.WORDS_PER_VREG (WORDS_PER_VREG)
	) u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.elem_size       (elem_size),
		.dest_reg        (dest_reg),
		.src_reg         (src_reg),
		.small_imm       (small_imm),
		.pattern_imm     (pattern_imm),
		.load_word_index (load_word_index),
		.load_word_data  (load_word_data),
		.q_full          (q_full),
		.push            (push),
		.cmd             (push_cmd)
	);

	viu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	viu_back #(
		.NUM_VREGS      (NUM_VREGS),
		.WORDS_PER_VREG (WORDS_PER_VREG)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.written_reg (written_reg),
		.word_index  (word_index),
		.word_value  (word_value),
		.last_word   (last_word)
	);

endmodule

// ===== design/viu_checker.sv =====
// ----------------------------------------------------------------------------
// viu_assertions
// Port-level checks on the result channel of the vector immediate unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module viu_assertions #(
	parameter int NUM_VREGS      = 32,
	parameter int WORDS_PER_VREG = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  written_reg,
	input logic [1:0]  word_index,
	input logic [63:0] word_value,
	input logic        last_word
);

	logic [71:0] out_word;
	logic        top_word;

	assign out_word = {written_reg, word_index, word_value, last_word};
	assign top_word = (int'(word_index) == WORDS_PER_VREG - 1);

	`VIU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
	`VIU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled word changed")
	`VIU_ASSERT_IMPL(a_reg_range, out_valid, int'(written_reg) < NUM_VREGS, "bad register")
	`VIU_ASSERT_IMPL(a_word_range, out_valid, int'(word_index) < WORDS_PER_VREG, "bad word index")
	`VIU_ASSERT_IMPL(a_top_is_last, out_valid && top_word, last_word, "top word not last")

endmodule

bind vector_immediate_unit viu_assertions #(
	.NUM_VREGS      (NUM_VREGS),
	.WORDS_PER_VREG (WORDS_PER_VREG)
) u_viu_assertions (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.written_reg (written_reg),
	.word_index  (word_index),
	.word_value  (word_value),
	.last_word   (last_word)
);
